// File: hdl/tcdt_pkg.sv
// Shared types, codes and helpers for the tick counter with deadline timers.
// Used by every module of the block; depends on nothing else.
package tcdt_pkg;

   // Number of timer slots and the widths that follow from it.
   localparam int MAX_TIMERS = 16;
   localparam int SLOT_W     = 4;
   localparam int CNT_W      = 5;

   // Input command codes as they arrive on the request channel.
   localparam logic [1:0] CMD_TICK   = 2'd0;
   localparam logic [1:0] CMD_START  = 2'd1;
   localparam logic [1:0] CMD_CANCEL = 2'd2;

   // Classified operations handed from the front part to the back part.
   localparam logic [1:0] OP_TICK   = 2'd0;
   localparam logic [1:0] OP_START  = 2'd1;
   localparam logic [1:0] OP_CANCEL = 2'd2;

   // Result event kinds.
   localparam logic [2:0] EV_STARTED    = 3'd0;
   localparam logic [2:0] EV_FULL       = 3'd1;
   localparam logic [2:0] EV_CANCELLED  = 3'd2;
   localparam logic [2:0] EV_NOT_ACTIVE = 3'd3;
   localparam logic [2:0] EV_EXPIRED    = 3'd4;
   localparam logic [2:0] EV_TICK_DONE  = 3'd5;

   // One classified command.
   typedef struct packed {
      logic [1:0]        op;
      logic [31:0]       delay;
      logic [31:0]       tag;
      logic [SLOT_W-1:0] handle;
   } cmd_type;

   // Status of the back part, seen by the top level.
   typedef struct packed {
      logic [CNT_W-1:0] active_count;
   } status_type;

   // True when a - b, as a signed 32-bit difference, is greater than zero.
   function automatic logic later_than(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] d;
      d = a - b;
      return (d != 32'd0) && !d[31];
   endfunction

endpackage

// File: hdl/tcdt_front.sv
// Front part: accepts request transactions and classifies them into commands.
// Depends on tcdt_pkg.
module tcdt_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [71:0]         req_tdata,   // delay_ticks, user_tag, slot_handle, zero pad
   input  logic [1:0]          req_tuser,   // cmd
   output logic                push_valid,
   output tcdt_pkg::cmd_type   push_cmd,
   input  logic                push_ready
);

   logic                accepted_ff, accepted_in;
   tcdt_pkg::cmd_type   cmd_ff, cmd_in;

   // The front holds one classified command until the queue takes it.
   assign req_tready = !accepted_ff || push_ready;
   assign push_valid = accepted_ff;
   assign push_cmd   = cmd_ff;

   // Classify the command; the unused code is handled as a tick.
   always_comb begin
      cmd_in      = cmd_ff;
      accepted_in = accepted_ff;
      if (push_ready) begin
         accepted_in = 1'b0;
      end
      if (req_tvalid && req_tready) begin
         accepted_in   = 1'b1;
         cmd_in.delay  = req_tdata[31:0];
         cmd_in.tag    = req_tdata[63:32];
         cmd_in.handle = req_tdata[67:64];
         unique case (req_tuser)
            tcdt_pkg::CMD_START:  cmd_in.op = tcdt_pkg::OP_START;
            tcdt_pkg::CMD_CANCEL: cmd_in.op = tcdt_pkg::OP_CANCEL;
            default:              cmd_in.op = tcdt_pkg::OP_TICK;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accepted_ff <= 1'b0;
      end else begin
         accepted_ff <= accepted_in;
      end
      cmd_ff <= cmd_in;
   end

endmodule

// File: hdl/tcdt_queue.sv
// Two-entry command queue between the front part and the back part.
// Depends on tcdt_pkg.
module tcdt_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   input  tcdt_pkg::cmd_type   push_cmd,
   output logic                push_ready,
   output logic                pop_valid,
   output tcdt_pkg::cmd_type   pop_cmd,
   input  logic                pop
);

   tcdt_pkg::cmd_type   entry_ff [2];
   tcdt_pkg::cmd_type   entry_in [2];
   logic                wr_ptr_ff, wr_ptr_in;
   logic                rd_ptr_ff, rd_ptr_in;
   logic [1:0]          count_ff, count_in;
   logic                do_push, do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_cmd    = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   // Pointer and fill count update.
   always_comb begin
      entry_in  = entry_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         entry_in[wr_ptr_ff] = push_cmd;
         wr_ptr_in           = !wr_ptr_ff;
      end
      if (do_pop) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      entry_ff <= entry_in;
   end

endmodule

// File: hdl/tcdt_back.sv
// Back part: counters, timer table, expiry order and the result register.
// Depends on tcdt_pkg.
module tcdt_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   cmd_valid,
   input  tcdt_pkg::cmd_type      cmd,
   output logic                   cmd_pop,
   input  logic                   csr_write,
   input  logic [15:0]            csr_value,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [103:0]           rsp_tdata,
   output logic [2:0]             rsp_tuser,
   output logic                   rsp_tlast,
   output tcdt_pkg::status_type   status
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_INSERT = 2'd1;
   localparam logic [1:0] ST_SCAN   = 2'd2;

   localparam int SW = tcdt_pkg::SLOT_W;
   localparam int CW = tcdt_pkg::CNT_W;
   localparam int MT = tcdt_pkg::MAX_TIMERS;

   logic [1:0]    state_ff, state_in;
   logic [CW-1:0] pos_ff, pos_in;
   logic [31:0]   dl_ff, dl_in;
   logic [31:0]   ptag_ff, ptag_in;
   logic [SW-1:0] pslot_ff, pslot_in;
   logic [31:0]   tick_ff, tick_in;
   logic [15:0]   sub_ff, sub_in;
   logic [31:0]   up_ff, up_in;
   logic [15:0]   tps_ff, tps_in;
   logic [MT-1:0] active_ff, active_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [SW-1:0] order_ff [MT];
   logic [SW-1:0] order_in [MT];
   logic [31:0]   dlmem_ff [MT];
   logic [31:0]   dlmem_in [MT];
   logic [31:0]   tagmem_ff [MT];
   logic [31:0]   tagmem_in [MT];

   logic          ovalid_ff, ovalid_in;
   logic [2:0]    okind_ff, okind_in;
   logic [SW-1:0] ohandle_ff, ohandle_in;
   logic [31:0]   otag_ff, otag_in;
   logic [31:0]   otick_ff, otick_in;
   logic [31:0]   oup_ff, oup_in;
   logic          olast_ff, olast_in;

   logic          out_free;
   logic [SW-1:0] rd_slot;
   logic [31:0]   rd_dl;
   logic [31:0]   rd_tag;
   logic [SW-1:0] free_slot;
   logic [SW-1:0] cancel_pos;
   logic          found;
   logic [16:0]   sub_next;

   assign out_free   = !ovalid_ff || rsp_tready;
   assign rsp_tvalid = ovalid_ff;
   assign rsp_tuser  = okind_ff;
   assign rsp_tlast  = olast_ff;
   assign rsp_tdata  = {4'd0, oup_ff, otick_ff, otag_ff, ohandle_ff};
   assign status.active_count = cnt_ff;

   // Single read port of the slot table, addressed by the head or the search position.
   assign rd_slot = (state_ff == ST_SCAN) ? order_ff[0] : order_ff[pos_ff[SW-1:0]];
   assign rd_dl   = dlmem_ff[rd_slot];
   assign rd_tag  = tagmem_ff[rd_slot];
   assign found   = (pos_ff == cnt_ff) || tcdt_pkg::later_than(rd_dl, dl_ff);
   assign sub_next = {1'b0, sub_ff} + 17'd1;

   // Lowest free slot and position of the slot to cancel in the expiry order.
   always_comb begin
      free_slot  = '0;
      cancel_pos = '0;
      for (int i = MT - 1; i >= 0; i--) begin
         if (!active_ff[i]) begin
            free_slot = SW'(i);
         end
         if ((order_ff[i] == cmd.handle) && (CW'(i) < cnt_ff)) begin
            cancel_pos = SW'(i);
         end
      end
   end

   // Command sequencer.
   always_comb begin
      state_in   = state_ff;
      pos_in     = pos_ff;
      dl_in      = dl_ff;
      ptag_in    = ptag_ff;
      pslot_in   = pslot_ff;
      tick_in    = tick_ff;
      sub_in     = sub_ff;
      up_in      = up_ff;
      tps_in     = tps_ff;
      active_in  = active_ff;
      cnt_in     = cnt_ff;
      order_in   = order_ff;
      dlmem_in   = dlmem_ff;
      tagmem_in  = tagmem_ff;
      ovalid_in  = ovalid_ff && !rsp_tready;
      okind_in   = okind_ff;
      ohandle_in = ohandle_ff;
      otag_in    = otag_ff;
      otick_in   = tick_ff;
      oup_in     = up_ff;
      olast_in   = olast_ff;
      cmd_pop    = 1'b0;
      if (!ovalid_ff || rsp_tready) begin
         otick_in = tick_ff;
      end else begin
         otick_in = otick_ff;
         oup_in   = oup_ff;
      end

      if (csr_write) begin
         tps_in = csr_value;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && out_free) begin
               cmd_pop = 1'b1;
               unique case (cmd.op)
                  tcdt_pkg::OP_START: begin
                     if (cnt_ff == CW'(MT)) begin
                        ovalid_in  = 1'b1;
                        okind_in   = tcdt_pkg::EV_FULL;
                        ohandle_in = '0;
                        otag_in    = '0;
                        olast_in   = 1'b1;
                     end else begin
                        pslot_in = free_slot;
                        dl_in    = tick_ff + cmd.delay;
                        ptag_in  = cmd.tag;
                        pos_in   = '0;
                        state_in = ST_INSERT;
                     end
                  end
                  tcdt_pkg::OP_CANCEL: begin
                     ovalid_in  = 1'b1;
                     ohandle_in = cmd.handle;
                     otag_in    = '0;
                     olast_in   = 1'b1;
                     if (!active_ff[cmd.handle]) begin
                        okind_in = tcdt_pkg::EV_NOT_ACTIVE;
                     end else begin
                        okind_in = tcdt_pkg::EV_CANCELLED;
                        for (int i = 0; i < MT - 1; i++) begin
                           if (SW'(i) >= cancel_pos) begin
                              order_in[i] = order_ff[i+1];
                           end
                        end
                        cnt_in = cnt_ff - CW'(1);
                        active_in[cmd.handle] = 1'b0;
                     end
                  end
                  default: begin
                     tick_in = tick_ff + 32'd1;
                     if (sub_next >= {1'b0, tps_ff}) begin
                        sub_in = '0;
                        up_in  = up_ff + 32'd1;
                     end else begin
                        sub_in = sub_next[15:0];
                     end
                     state_in = ST_SCAN;
                  end
               endcase
            end
         end
         ST_INSERT: begin
            if (!found) begin
               pos_in = pos_ff + CW'(1);
            end else if (out_free) begin
               for (int i = 1; i < MT; i++) begin
                  if (CW'(i) > pos_ff) begin
                     order_in[i] = order_ff[i-1];
                  end
               end
               order_in[pos_ff[SW-1:0]] = pslot_ff;
               cnt_in                   = cnt_ff + CW'(1);
               dlmem_in[pslot_ff]       = dl_ff;
               tagmem_in[pslot_ff]      = ptag_ff;
               active_in[pslot_ff]      = 1'b1;
               ovalid_in  = 1'b1;
               okind_in   = tcdt_pkg::EV_STARTED;
               ohandle_in = pslot_ff;
               otag_in    = '0;
               olast_in   = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (out_free) begin
               ovalid_in = 1'b1;
               if ((cnt_ff != '0) && !tcdt_pkg::later_than(rd_dl, tick_ff)) begin
                  for (int i = 0; i < MT - 1; i++) begin
                     order_in[i] = order_ff[i+1];
                  end
                  cnt_in             = cnt_ff - CW'(1);
                  active_in[rd_slot] = 1'b0;
                  okind_in   = tcdt_pkg::EV_EXPIRED;
                  ohandle_in = rd_slot;
                  otag_in    = rd_tag;
                  olast_in   = 1'b0;
               end else begin
                  okind_in   = tcdt_pkg::EV_TICK_DONE;
                  ohandle_in = '0;
                  otag_in    = '0;
                  olast_in   = 1'b1;
                  state_in   = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         tick_ff   <= '0;
         sub_ff    <= '0;
         up_ff     <= '0;
         tps_ff    <= 16'd100;
         active_ff <= '0;
         cnt_ff    <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         tick_ff   <= tick_in;
         sub_ff    <= sub_in;
         up_ff     <= up_in;
         tps_ff    <= tps_in;
         active_ff <= active_in;
         cnt_ff    <= cnt_in;
         ovalid_ff <= ovalid_in;
      end
      pos_ff     <= pos_in;
      dl_ff      <= dl_in;
      ptag_ff    <= ptag_in;
      pslot_ff   <= pslot_in;
      order_ff   <= order_in;
      dlmem_ff   <= dlmem_in;
      tagmem_ff  <= tagmem_in;
      okind_ff   <= okind_in;
      ohandle_ff <= ohandle_in;
      otag_ff    <= otag_in;
      otick_ff   <= otick_in;
      oup_ff     <= oup_in;
      olast_ff   <= olast_in;
   end

endmodule

// File: hdl/tick_counter_with_deadline_timers.sv
// Top level of the tick counter with deadline timers.
// Depends on tcdt_pkg, tcdt_front, tcdt_queue and tcdt_back.
//
// Usage: request transactions carry a command in req_tuser (tick, start, cancel).
// A start returns one result with the slot handle or a table-full kind; a cancel
// returns one result. A tick advances the tick and uptime counters, then returns
// one result per expired timer in deadline order and closes with a tick-done
// result, which carries rsp_tlast. The csr port writes ticks_per_second.
// A cancel or a full start passes the front register and the queue, and the
// sequencer then sets its result in the result register. A start walks the
// expiry order one entry a cycle. A tick gives one result per cycle while the
// receiver takes them. The rate is set by the sequencer in the back part, which
// handles one command at a time and reads the timer table through a single read
// port. A two-entry queue lets the request side run ahead of it.
// Reset clears the counters, marks all slots free and sets ticks_per_second
// to 100. When the receiver stalls, the result register holds its transaction
// and the sequencer waits; requests are taken until the queue is full.
module tick_counter_with_deadline_timers (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [71:0]   req_tdata,   // delay_ticks, user_tag, slot_handle, zero pad
   input  logic [1:0]    req_tuser,   // cmd
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [103:0]  rsp_tdata,   // result_handle, result_tag, tick_now, uptime_seconds, pad
   output logic [2:0]    rsp_tuser,   // event_kind
   output logic          rsp_tlast,   // last
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [15:0]   csr_data     // ticks_per_second
);

   logic                  push_valid, push_ready;
   tcdt_pkg::cmd_type     push_cmd;
   logic                  pop_valid, pop;
   tcdt_pkg::cmd_type     pop_cmd;
   tcdt_pkg::status_type  status;

   assign csr_ready = 1'b1;

   // Request side.
   tcdt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .push_ready (push_ready)
   );

   // Command queue.
   tcdt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_cmd    (pop_cmd),
      .pop        (pop)
   );

   // Timer engine and result register.
   tcdt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (pop_valid),
      .cmd        (pop_cmd),
      .cmd_pop    (pop),
      .csr_write  (csr_valid && csr_ready),
      .csr_value  (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .status     (status)
   );

`ifndef SYNTHESIS
   // The table never holds more timers than it has slots.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      status.active_count <= tcdt_pkg::CNT_W'(tcdt_pkg::MAX_TIMERS))
      else $error("active timer count out of range");

   // Expired results are never the final result of a tick.
   a_expired_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == tcdt_pkg::EV_EXPIRED) |-> !rsp_tlast)
      else $error("expired result marked last");

   // A tick-done result always closes its transaction group.
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == tcdt_pkg::EV_TICK_DONE) |-> rsp_tlast)
      else $error("tick-done result not marked last");

   // A shown start result implies at least one active timer.
   a_started_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == tcdt_pkg::EV_STARTED) |-> status.active_count != '0)
      else $error("start reported with empty table");
`endif

endmodule
